### sv/ale_pkg.sv
// shared constants, codes and controller/datapath interface types
package ale_pkg;

    localparam int L_MAX = 12;
    localparam logic [3:0] L_MAX_V = 4'(L_MAX);

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    // multiplier operand sources
    localparam logic [2:0] SRC_POW  = 3'd0;
    localparam logic [2:0] SRC_SEED = 3'd1;
    localparam logic [2:0] SRC_P1   = 3'd2;
    localparam logic [2:0] SRC_A    = 3'd3;
    localparam logic [2:0] SRC_B    = 3'd4;

    // result selection
    localparam logic [1:0] SEL_INVALID = 2'd0;
    localparam logic [1:0] SEL_PMM     = 2'd1;
    localparam logic [1:0] SEL_PMMP1   = 2'd2;

    typedef struct packed {
        logic       load;
        logic       check;
        logic       sqrt_step;
        logic       mul_clr;
        logic       mul_step;
        logic [1:0] part;
        logic       mul_fin;
        logic       sub;
        logic       div_step;
        logic       advance;
        logic       emit;
        logic [1:0] sel;
        logic [2:0] src;
        logic [3:0] idx;
    } cmd_t;

    typedef struct packed {
        logic       invalid;
        logic [3:0] l;
        logic [3:0] m;
    } stat_t;

endpackage

### sv/ale_dp.sv
// datapath: argument check, bit-serial square root, shared multiplier, digit divider
module ale_dp
    import ale_pkg::*;
(
    input  logic               clk,
    input  cmd_t               cmd,
    input  logic [3:0]         degree,
    input  logic signed [4:0]  order,
    input  logic signed [31:0] arg_x,
    output stat_t              stat,
    output logic signed [63:0] value,
    output logic [1:0]         status
);

    localparam logic [62:0] MAX63 = '1;

    logic [3:0]         l_reg, m_reg;
    logic signed [31:0] x_reg;
    logic               inv_reg, ov_reg;
    logic [63:0]        sq_t_reg, sq_res_reg, sq_bit_reg;
    logic [30:0]        p_reg;
    logic [63:0]        df_reg;
    logic signed [63:0] pmm_reg, pmmp1_reg, ta_reg, tb_reg;
    logic [63:0]        ma_reg, mb_reg;
    logic               neg_reg;
    logic [4:0]         sh_reg;
    logic [127:0]       acc_reg;
    logic               nneg_reg;
    logic [63:0]        dvd_reg;
    logic [3:0]         rem_reg, dd_reg;
    logic signed [63:0] value_reg;
    logic [1:0]         status_reg;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? (~v + 64'd1) : v;
    endfunction

    // input check
    logic        inv_in;
    logic signed [32:0] x_ext;
    always_comb
    begin
        x_ext  = {arg_x[31], arg_x};
        inv_in = order[4] || ({1'b0, order[3:0]} > {1'b0, degree}) || (degree > L_MAX_V)
                 || (x_ext > 33'sd1073741824) || (x_ext < -33'sd1073741824);
    end

    // radicand (1-x)(1+x) in Q60
    logic signed [32:0] one_m, one_p;
    logic [63:0]        rad;
    always_comb
    begin
        one_m = 33'sd1073741824 - {x_reg[31], x_reg};
        one_p = 33'sd1073741824 + {x_reg[31], x_reg};
        rad   = one_m[31:0] * one_p[31:0];
    end

    // square root step
    logic [63:0] sq_sum;
    assign sq_sum = sq_res_reg + sq_bit_reg;

    // multiplier operand select
    logic [30:0] xm;
    logic [4:0]  kx, kb, kpow;
    logic [35:0] xk;
    logic [63:0] op_a, op_b;
    logic        op_neg;
    logic [4:0]  op_sh;
    always_comb
    begin
        xm   = x_reg[31] ? 31'(~x_reg + 32'd1) : x_reg[30:0];
        kx   = {cmd.idx, 1'b0} - 5'd1;
        kpow = kx;
        kb   = {1'b0, cmd.idx} + {1'b0, m_reg} - 5'd1;
        xk   = xm * kx;
        unique case (cmd.src)
            SRC_SEED:
            begin
                op_a = df_reg; op_b = {33'd0, p_reg}; op_neg = m_reg[0]; op_sh = 5'd6;
            end
            SRC_P1:
            begin
                op_a = {28'd0, xk}; op_b = mag64(pmm_reg);
                op_neg = x_reg[31] ^ pmm_reg[63]; op_sh = 5'd30;
            end
            SRC_A:
            begin
                op_a = {28'd0, xk}; op_b = mag64(pmmp1_reg);
                op_neg = x_reg[31] ^ pmmp1_reg[63]; op_sh = 5'd30;
            end
            SRC_B:
            begin
                op_a = {59'd0, kb}; op_b = mag64(pmm_reg); op_neg = pmm_reg[63]; op_sh = 5'd0;
            end
            default:
            begin
                op_a = {33'd0, p_reg}; op_b = sq_res_reg; op_neg = 1'b0; op_sh = 5'd30;
            end
        endcase
    end

    // one 32x32 partial product per cycle
    logic [31:0]  ah, bh;
    logic [63:0]  pp;
    logic [1:0]   nsh;
    logic [127:0] pp_sh;
    always_comb
    begin
        ah    = cmd.part[0] ? ma_reg[63:32] : ma_reg[31:0];
        bh    = cmd.part[1] ? mb_reg[63:32] : mb_reg[31:0];
        pp    = ah * bh;
        nsh   = {1'b0, cmd.part[0]} + {1'b0, cmd.part[1]};
        pp_sh = {64'd0, pp} << {nsh, 5'd0};
    end

    // round, rescale, saturate
    logic [127:0]       rnd, rsum, rshr;
    logic               msat;
    logic [62:0]        mmag;
    logic signed [63:0] mres;
    always_comb
    begin
        rnd  = (sh_reg == 5'd0) ? 128'd0 : (128'd1 << (sh_reg - 5'd1));
        rsum = acc_reg + rnd;
        rshr = rsum >> sh_reg;
        msat = |rshr[127:63];
        mmag = msat ? MAX63 : rshr[62:0];
        mres = neg_reg ? -$signed({1'b0, mmag}) : $signed({1'b0, mmag});
    end

    // saturating difference and divisor
    logic signed [64:0] diff;
    logic signed [63:0] diff_c;
    logic               dsat;
    logic [3:0]         dd;
    always_comb
    begin
        diff   = {ta_reg[63], ta_reg} - {tb_reg[63], tb_reg};
        dsat   = 1'b0;
        diff_c = diff[63:0];
        if (diff > $signed({2'b00, MAX63}))
        begin
            diff_c = $signed({1'b0, MAX63});
            dsat   = 1'b1;
        end
        else if (diff < -$signed({2'b00, MAX63}))
        begin
            diff_c = -$signed({1'b0, MAX63});
            dsat   = 1'b1;
        end
        dd = cmd.idx - m_reg;
    end

    // four quotient bits per cycle
    logic [3:0]  dr;
    logic [63:0] dq;
    logic [4:0]  t5;
    always_comb
    begin
        dr = rem_reg;
        dq = dvd_reg;
        for (int j = 0; j < 4; j++)
        begin
            t5 = {dr, dq[63]};
            dq = {dq[62:0], 1'b0};
            if (t5 >= {1'b0, dd_reg})
            begin
                dr    = 4'(t5 - {1'b0, dd_reg});
                dq[0] = 1'b1;
            end
            else
            begin
                dr = t5[3:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            l_reg   <= degree;
            m_reg   <= order[3:0];
            x_reg   <= arg_x;
            inv_reg <= inv_in;
            ov_reg  <= 1'b0;
            p_reg   <= 31'h4000_0000;
            df_reg  <= 64'd1;
        end
        if (cmd.check)
        begin
            sq_t_reg   <= rad;
            sq_res_reg <= 64'd0;
            sq_bit_reg <= 64'd1 << 62;
        end
        if (cmd.sqrt_step)
        begin
            if (sq_t_reg >= sq_sum)
            begin
                sq_t_reg   <= sq_t_reg - sq_sum;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (cmd.mul_clr)
        begin
            ma_reg  <= op_a;
            mb_reg  <= op_b;
            neg_reg <= op_neg;
            sh_reg  <= op_sh;
            acc_reg <= 128'd0;
        end
        if (cmd.mul_step)
            acc_reg <= acc_reg + pp_sh;
        if (cmd.mul_fin)
        begin
            if (msat)
                ov_reg <= 1'b1;
            unique case (cmd.src)
                SRC_SEED: pmm_reg   <= mres;
                SRC_P1:   pmmp1_reg <= mres;
                SRC_A:    ta_reg    <= mres;
                SRC_B:    tb_reg    <= mres;
                default:
                begin
                    p_reg  <= mmag[30:0];
                    df_reg <= 64'(df_reg * kpow);
                end
            endcase
        end
        if (cmd.sub)
        begin
            if (dsat)
                ov_reg <= 1'b1;
            nneg_reg <= diff_c[63];
            dvd_reg  <= mag64(diff_c) + {61'd0, dd[3:1]};
            dd_reg   <= dd;
            rem_reg  <= 4'd0;
        end
        if (cmd.div_step)
        begin
            dvd_reg <= dq;
            rem_reg <= dr;
        end
        if (cmd.advance)
        begin
            pmm_reg   <= pmmp1_reg;
            pmmp1_reg <= nneg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);
        end
        if (cmd.emit)
        begin
            unique case (cmd.sel)
                SEL_PMM:   value_reg <= pmm_reg;
                SEL_PMMP1: value_reg <= pmmp1_reg;
                default:   value_reg <= 64'sd0;
            endcase
            if (cmd.sel == SEL_INVALID)
                status_reg <= ST_INVALID;
            else
                status_reg <= ov_reg ? ST_SAT : ST_OK;
        end
    end

    assign stat   = '{invalid: inv_reg, l: l_reg, m: m_reg};
    assign value  = value_reg;
    assign status = status_reg;

endmodule

### sv/ale_ctrl.sv
// controller state machine sequencing root, power loop, seed and recurrence
module ale_ctrl
    import ale_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy,
    output logic  done
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_SQRT    = 4'd2;
    localparam logic [3:0] S_POWCHK  = 4'd3;
    localparam logic [3:0] S_MCLR    = 4'd4;
    localparam logic [3:0] S_MSTEP   = 4'd5;
    localparam logic [3:0] S_MFIN    = 4'd6;
    localparam logic [3:0] S_LOOPCHK = 4'd7;
    localparam logic [3:0] S_SUB     = 4'd8;
    localparam logic [3:0] S_DIV     = 4'd9;
    localparam logic [3:0] S_ADV     = 4'd10;
    localparam logic [3:0] S_EMIT    = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [4:0] idx_reg, idx_next;
    logic [2:0] src_reg, src_next;
    logic [1:0] sel_reg, sel_next;
    logic       done_reg, done_next;

    logic [4:0] m5, l5;
    assign m5 = {1'b0, stat.m};
    assign l5 = {1'b0, stat.l};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        src_next   = src_reg;
        sel_next   = sel_reg;
        done_next  = (state_reg == S_EMIT);
        unique case (state_reg)
            S_IDLE:
                if (start)
                    state_next = S_CHECK;
            S_CHECK:
            begin
                cnt_next = 5'd0;
                if (stat.invalid)
                begin
                    sel_next   = SEL_INVALID;
                    state_next = S_EMIT;
                end
                else
                    state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    idx_next   = 5'd1;
                    state_next = S_POWCHK;
                end
            end
            S_POWCHK:
            begin
                src_next   = (idx_reg > m5) ? SRC_SEED : SRC_POW;
                state_next = S_MCLR;
            end
            S_MCLR:
            begin
                cnt_next   = 5'd0;
                state_next = S_MSTEP;
            end
            S_MSTEP:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg[1:0] == 2'd3)
                    state_next = S_MFIN;
            end
            S_MFIN:
            begin
                unique case (src_reg)
                    SRC_SEED:
                        if (l5 == m5)
                        begin
                            sel_next   = SEL_PMM;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            src_next   = SRC_P1;
                            idx_next   = m5 + 5'd1;
                            state_next = S_MCLR;
                        end
                    SRC_P1:
                    begin
                        idx_next   = m5 + 5'd2;
                        state_next = S_LOOPCHK;
                    end
                    SRC_A:
                    begin
                        src_next   = SRC_B;
                        state_next = S_MCLR;
                    end
                    SRC_B:
                        state_next = S_SUB;
                    default:
                    begin
                        idx_next   = idx_reg + 5'd1;
                        state_next = S_POWCHK;
                    end
                endcase
            end
            S_LOOPCHK:
                if (idx_reg > l5)
                begin
                    sel_next   = SEL_PMMP1;
                    state_next = S_EMIT;
                end
                else
                begin
                    src_next   = SRC_A;
                    state_next = S_MCLR;
                end
            S_SUB:
            begin
                cnt_next   = 5'd0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                    state_next = S_ADV;
            end
            S_ADV:
            begin
                idx_next   = idx_reg + 5'd1;
                state_next = S_LOOPCHK;
            end
            S_EMIT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 5'd0;
            idx_reg   <= 5'd0;
            src_reg   <= SRC_POW;
            sel_reg   <= SEL_INVALID;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            src_reg   <= src_next;
            sel_reg   <= sel_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        cmd           = '0;
        cmd.load      = (state_reg == S_IDLE) && start;
        cmd.check     = (state_reg == S_CHECK);
        cmd.sqrt_step = (state_reg == S_SQRT);
        cmd.mul_clr   = (state_reg == S_MCLR);
        cmd.mul_step  = (state_reg == S_MSTEP);
        cmd.part      = cnt_reg[1:0];
        cmd.mul_fin   = (state_reg == S_MFIN);
        cmd.sub       = (state_reg == S_SUB);
        cmd.div_step  = (state_reg == S_DIV);
        cmd.advance   = (state_reg == S_ADV);
        cmd.emit      = (state_reg == S_EMIT);
        cmd.sel       = sel_reg;
        cmd.src       = src_reg;
        cmd.idx       = idx_reg[3:0];
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    a_done_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_EMIT))
        else $error("result strobe without emit");

    a_start_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (state_reg == S_CHECK))
        else $error("start not taken in idle");

    a_mul_four_parts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MSTEP && cnt_reg[1:0] == 2'd3) |=> (state_reg == S_MFIN))
        else $error("multiply did not finish after four partial products");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg <= 5'd15))
        else $error("divider ran past sixteen digits");

endmodule

### sv/associated_legendre_eval_top.sv
// top level of the associated Legendre function evaluator
//
// evaluates P_l^m(x) with the Condon-Shortley sign, x in Q2.30, result in Q40.24
// input channel: degree, order, arg_x are taken on a rising edge with start high
//   and busy low; one transaction at a time, busy stays high until the result
// output channel: value and status are shown for exactly one cycle with done high;
//   the receiver cannot stall, so nothing is held back
// status: 0 ok, 1 invalid arguments (value zero), 2 an intermediate saturated
// sequence: invalid arguments go straight to the result; otherwise the root,
//   the power loop and the seed, then the recurrence when l > m
// the root is bit-serial, each 64x64 product takes four 32x32 partial products on
// one shared multiplier, each division by (i-m) yields four quotient bits per step
// a new transaction can start in the cycle that done is high
// reset clears the controller; no result is pending after reset
module associated_legendre_eval_top
    import ale_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [3:0]         degree,
    input  logic signed [4:0]  order,
    input  logic signed [31:0] arg_x,
    output logic               busy,
    output logic               done,
    output logic signed [63:0] value,
    output logic [1:0]         status
);

    // command and status between sequencer and datapath
    cmd_t  cmd;
    stat_t stat;

    ale_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ale_dp u_dp (
        .clk    (clk),
        .cmd    (cmd),
        .degree (degree),
        .order  (order),
        .arg_x  (arg_x),
        .stat   (stat),
        .value  (value),
        .status (status)
    );

endmodule

### tb/associated_legendre_eval_top_tb.sv
// testbench for the associated Legendre function evaluator: bit-exact prediction and checking
module associated_legendre_eval_top_tb
    import ale_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ONE_X   = 64'sd1 << 30;
    localparam int     N_RAND  = 1230;
    localparam longint LIMIT   = 2_000_000;

    // expected result of one transaction
    typedef struct {
        logic signed [63:0] value;
        logic [1:0]         status;
    } legendre_res_t;

    // scoreboard: computes P_l^m(x) for each accepted transaction and checks results in order
    class legendre_scoreboard;
        legendre_res_t pending[$];
        int            mismatches;

        // magnitude of a signed 64-bit value, as unsigned
        static function logic [63:0] mag(logic signed [63:0] v);
            return v < 0 ? 64'd0 - 64'(v) : 64'(v);
        endfunction

        static function logic signed [63:0] clip(logic neg, logic [63:0] m, ref logic ovf);
            if (m > 64'(SAT_MAX))
            begin
                ovf = 1'b1;
                m = 64'(SAT_MAX);
            end
            return neg ? -$signed(m) : $signed(m);
        endfunction

        // round(a*b / 2^sh), magnitude rounded half away from zero, saturating
        static function logic signed [63:0] scaled_product(logic signed [63:0] a,
                logic signed [63:0] b, int sh, ref logic ovf);
            logic [127:0] prod;
            logic         neg;
            neg  = (a < 0) != (b < 0);
            prod = 128'(mag(a)) * 128'(mag(b));
            if (sh > 0)
                prod = (prod + (128'd1 << (sh - 1))) >> sh;
            if (prod[127:64] != 0)
            begin
                ovf = 1'b1;
                prod = 128'(SAT_MAX);
            end
            return clip(neg, prod[63:0], ovf);
        endfunction

        static function logic signed [63:0] diff_sat(logic signed [63:0] a,
                logic signed [63:0] b, ref logic ovf);
            logic signed [64:0] d;
            d = 65'(a) - 65'(b);
            if (d > 65'(SAT_MAX))
            begin
                ovf = 1'b1;
                return SAT_MAX;
            end
            if (d < -65'(SAT_MAX))
            begin
                ovf = 1'b1;
                return -SAT_MAX;
            end
            return d[63:0];
        endfunction

        static function logic [63:0] int_root(logic [63:0] t);
            logic [63:0] r, bt;
            r = 0;
            bt = 64'd1 << 62;
            while (bt > t)
                bt >>= 2;
            while (bt != 0)
            begin
                if (t >= r + bt)
                begin
                    t = t - (r + bt);
                    r = (r >> 1) + bt;
                end
                else
                    r >>= 1;
                bt >>= 2;
            end
            return r;
        endfunction

        static function legendre_res_t evaluate(logic [3:0] l_in, logic signed [4:0] m_in,
                logic signed [31:0] x_in);
            legendre_res_t      r;
            logic signed [63:0] x, l, m, pm, pm1, a, b, nx, num;
            logic [63:0]        s, p, df, q, d;
            logic               ovf;
            x = x_in;
            l = l_in;
            m = m_in;
            ovf = 1'b0;
            if (m < 0 || m > l || l > L_MAX || x > ONE_X || x < -ONE_X)
            begin
                r.value = 0;
                r.status = ST_INVALID;
                return r;
            end
            s = int_root(64'(ONE_X - x) * 64'(ONE_X + x));
            p = 64'(ONE_X);
            df = 1;
            for (int i = 1; i <= m; i++)
            begin
                p = (p * s + (64'd1 << 29)) >> 30;
                df = df * 64'(2 * i - 1);
            end
            pm = scaled_product(df, p, 6, ovf);
            if (m[0])
                pm = -pm;
            if (l == m)
                r.value = pm;
            else
            begin
                pm1 = scaled_product(x * (2 * m + 1), pm, 30, ovf);
                for (longint i = m + 2; i <= l; i++)
                begin
                    a = scaled_product(x * (2 * i - 1), pm1, 30, ovf);
                    b = scaled_product(i + m - 1, pm, 0, ovf);
                    num = diff_sat(a, b, ovf);
                    d = 64'(i - m);
                    q = (mag(num) + d / 2) / d;
                    nx = num < 0 ? -$signed(q) : $signed(q);
                    pm = pm1;
                    pm1 = nx;
                end
                r.value = pm1;
            end
            r.status = ovf ? ST_SAT : ST_OK;
            return r;
        endfunction

        function void note_request(logic [3:0] l, logic signed [4:0] m, logic signed [31:0] x);
            pending.push_back(evaluate(l, m, x));
        endfunction

        function void check_result(logic signed [63:0] v, logic [1:0] st);
            legendre_res_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %0d status %0d", v, st);
                return;
            end
            e = pending.pop_front();
            if (v !== e.value || st !== e.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                        e.value, e.status, v, st);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic [3:0]         degree;
    logic signed [4:0]  order;
    logic signed [31:0] arg_x;
    logic               busy;
    logic               done;
    logic signed [63:0] value;
    logic [1:0]         status;

    legendre_scoreboard sb;
    longint             cycles;

    associated_legendre_eval_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .degree (degree),
        .order  (order),
        .arg_x  (arg_x),
        .busy   (busy),
        .done   (done),
        .value  (value),
        .status (status)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // results are taken at the edge that ends the done cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(value, status);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("associated_legendre_eval_top_tb failed");
            $finish;
        end
    end

    // random-length gap, mostly short, a few long, some runs with none
    task automatic idle_gap();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: n = 0;
            4, 5, 6, 7, 8: n = $urandom_range(1, 4);
            default: n = $urandom_range(10, 80);
        endcase
        if (n > 0)
            start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // offer one transaction and hold start until it is accepted
    task automatic send_request(logic [3:0] l, logic signed [4:0] m, logic signed [31:0] x);
        start <= 1'b1;
        degree <= l;
        order <= m;
        arg_x <= x;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(l, m, x);
    endtask

    // random argument: mostly valid in [-1, 1], with edges and some out of range
    function automatic logic signed [31:0] pick_x();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 32'sd1073741824 : -32'sd1073741824;
            1: return $urandom();
            2: return $urandom_range(0, 1) ? 32'sd1073741825 : -32'sd1073741825;
            default: return $signed($urandom_range(0, 32'h8000_0000)) - 32'sd1073741824;
        endcase
    endfunction

    initial
    begin
        logic [3:0]        l;
        logic signed [4:0] m;
        sb = new();
        cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        degree = '0;
        order = '0;
        arg_x = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, edges of x, invalid arguments
        send_request(4'd0, 5'sd0, 32'sd0);
        send_request(4'd12, 5'sd0, 32'sd1073741824);
        send_request(4'd12, 5'sd0, -32'sd1073741824);
        send_request(4'd12, 5'sd12, 32'sd0);
        send_request(4'd12, 5'sd12, 32'sd536870912);
        send_request(4'd12, 5'sd1, 32'sd123456789);
        send_request(4'd11, 5'sd11, -32'sd1);
        send_request(4'd12, 5'sd6, 32'sd1073741823);
        send_request(4'd1, 5'sd0, -32'sd1073741824);
        send_request(4'd5, 5'sd3, 32'sd700000000);
        send_request(4'd15, 5'sd0, 32'sd0);
        send_request(4'd13, 5'sd2, 32'sd1000);
        send_request(4'd3, -5'sd1, 32'sd0);
        send_request(4'd3, 5'sb10000, 32'sd0);
        send_request(4'd3, 5'sd15, 32'sd0);
        send_request(4'd2, 5'sd3, 32'sd0);
        send_request(4'd4, 5'sd1, 32'sd1073741825);
        send_request(4'd4, 5'sd1, -32'sd1073741825);
        send_request(4'd4, 5'sd1, 32'sh7FFF_FFFF);
        send_request(4'd4, 5'sd1, 32'sh8000_0000);
        send_request(4'd12, 5'sd12, -32'sd1073741824);

        for (int k = 0; k < N_RAND; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                l = 4'($urandom());
                m = 5'($urandom());
            end
            else
            begin
                l = 4'($urandom_range(0, L_MAX));
                m = 5'($urandom_range(0, l));
            end
            idle_gap();
            send_request(l, m, pick_x());
        end
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0)
            $display("associated_legendre_eval_top_tb passed");
        else
            $display("associated_legendre_eval_top_tb failed");
        $finish;
    end
endmodule
